FILE: hdl/wtmix_pkg.sv
// ----------------------------------------------------------------------------
// wtmix_pkg
// Shared constants, codes and types of the wavetable tone mixer.
// ----------------------------------------------------------------------------
package wtmix_pkg;

   localparam int NUM_VOICES_DEF      = 16;
   localparam int TABLE_DEPTH_DEF     = 128;
   localparam int PHASE_FRAC_BITS_DEF = 10;
   localparam int MIX_SHIFT_DEF       = 12;

   localparam int FUNC_W        = 2;
   localparam int VOICE_W       = 4;
   localparam int STEP_W        = 32;
   localparam int GAIN_W        = 8;
   localparam int TABLE_INDEX_W = 7;
   localparam int TABLE_VALUE_W = 16;
   localparam int DUTY_W        = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PERIOD_W   = 16;

   localparam logic [PERIOD_W-1:0] PWM_PERIOD_RESET = 16'd1406;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SET_VOICE  = 2'd0,
      FUNC_SAMPLE     = 2'd1,
      FUNC_LOAD_TABLE = 2'd2
   } func_type;

   typedef enum logic [0:0] {
      CSR_PWM_PERIOD = 1'b0
   } csr_reg_type;

   typedef struct packed {
      logic clr_we;
      logic set_we;
      logic load_we;
      logic acc_init;
      logic issue;
      logic out_load;
   } cmd_type;

endpackage

FILE: hdl/wtmix_req_if.sv
// ----------------------------------------------------------------------------
// wtmix_req_if
// Request channel: voice setup, sample and table load beats.
// ----------------------------------------------------------------------------
interface wtmix_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [wtmix_pkg::FUNC_W-1:0]            func;
   logic [wtmix_pkg::VOICE_W-1:0]           voice;
   logic [wtmix_pkg::STEP_W-1:0]            phase_step;
   logic [wtmix_pkg::GAIN_W-1:0]            gain;
   logic [wtmix_pkg::TABLE_INDEX_W-1:0]     table_index;
   logic signed [wtmix_pkg::TABLE_VALUE_W-1:0] table_value;

   modport source (output valid, func, voice, phase_step, gain, table_index, table_value,
                   input ready);
   modport sink (input valid, func, voice, phase_step, gain, table_index, table_value,
                 output ready);
endinterface

FILE: hdl/wtmix_rsp_if.sv
// ----------------------------------------------------------------------------
// wtmix_rsp_if
// Response channel: one duty beat per sample request.
// ----------------------------------------------------------------------------
interface wtmix_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wtmix_pkg::DUTY_W-1:0]  duty;
   logic                          clipped;

   modport source (output valid, duty, clipped, input ready);
   modport sink (input valid, duty, clipped, output ready);
endinterface

FILE: hdl/wtmix_ctrl.sv
// ----------------------------------------------------------------------------
// wtmix_ctrl
// Sequencer: memory clear after reset, request decode, voice issue,
// pipeline drain and response hand-off.
// ----------------------------------------------------------------------------
module wtmix_ctrl #(
   parameter int NUM_VOICES = wtmix_pkg::NUM_VOICES_DEF,
   parameter int CLR_DEPTH  = wtmix_pkg::TABLE_DEPTH_DEF,
   localparam int VOICE_AW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
   localparam int CLR_AW    = $clog2(CLR_DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [wtmix_pkg::FUNC_W-1:0]     req_func,
   output logic                             req_ready,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   input  logic                             pipe_busy,
   output wtmix_pkg::cmd_type               cmd,
   output logic [VOICE_AW-1:0]              issue_voice,
   output logic [CLR_AW-1:0]                clr_addr
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_ISSUE  = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   localparam logic [VOICE_AW-1:0] LAST_VOICE = VOICE_AW'(NUM_VOICES - 1);
   localparam logic [CLR_AW-1:0]   LAST_CLR   = CLR_AW'(CLR_DEPTH - 1);

   state_type           state_ff, state_in;
   logic [VOICE_AW-1:0] voice_cnt_ff, voice_cnt_in;
   logic [CLR_AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      voice_cnt_in = voice_cnt_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_we = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_CLR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == wtmix_pkg::FUNC_SET_VOICE) begin
                  cmd.set_we = 1'b1;
               end
               if (req_func == wtmix_pkg::FUNC_LOAD_TABLE) begin
                  cmd.load_we = 1'b1;
               end
               if (req_func == wtmix_pkg::FUNC_SAMPLE) begin
                  cmd.acc_init = 1'b1;
                  voice_cnt_in = '0;
                  state_in     = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            cmd.issue    = 1'b1;
            voice_cnt_in = voice_cnt_ff + 1'b1;
            if (voice_cnt_ff == LAST_VOICE) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         voice_cnt_ff <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         voice_cnt_ff <= voice_cnt_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign issue_voice = voice_cnt_ff;
   assign clr_addr    = clr_cnt_ff;

`ifndef SYNTHESIS
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken beat");
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_we, cmd.set_we, cmd.load_we, cmd.acc_init, cmd.issue, cmd.out_load}))
      else $error("overlapping datapath commands");
   a_last_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE && voice_cnt_ff == LAST_VOICE) |=> (state_ff == ST_DRAIN))
      else $error("issue did not stop after last voice");
`endif

endmodule

FILE: hdl/wtmix_dp.sv
// ----------------------------------------------------------------------------
// wtmix_dp
// Datapath: voice and table memories, phase update, table lookup,
// multiply-accumulate pipeline and saturating output register.
// ----------------------------------------------------------------------------
module wtmix_dp #(
   parameter int NUM_VOICES      = wtmix_pkg::NUM_VOICES_DEF,
   parameter int TABLE_DEPTH     = wtmix_pkg::TABLE_DEPTH_DEF,
   parameter int PHASE_FRAC_BITS = wtmix_pkg::PHASE_FRAC_BITS_DEF,
   parameter int MIX_SHIFT       = wtmix_pkg::MIX_SHIFT_DEF,
   parameter int CLR_DEPTH       = wtmix_pkg::TABLE_DEPTH_DEF,
   localparam int VOICE_AW       = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
   localparam int CLR_AW         = $clog2(CLR_DEPTH)
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  wtmix_pkg::cmd_type                         cmd,
   input  logic [VOICE_AW-1:0]                        issue_voice,
   input  logic [CLR_AW-1:0]                          clr_addr,
   input  logic [wtmix_pkg::VOICE_W-1:0]              req_voice,
   input  logic [wtmix_pkg::STEP_W-1:0]               req_phase_step,
   input  logic [wtmix_pkg::GAIN_W-1:0]               req_gain,
   input  logic [wtmix_pkg::TABLE_INDEX_W-1:0]        req_table_index,
   input  logic signed [wtmix_pkg::TABLE_VALUE_W-1:0] req_table_value,
   input  logic [wtmix_pkg::PERIOD_W-1:0]             pwm_period,
   output logic                                       pipe_busy,
   output logic [wtmix_pkg::DUTY_W-1:0]               duty,
   output logic                                       clipped
);

   localparam int TABLE_AW = $clog2(TABLE_DEPTH);
   localparam int STEP_W   = wtmix_pkg::STEP_W;
   localparam int GAIN_W   = wtmix_pkg::GAIN_W;
   localparam int TV_W     = wtmix_pkg::TABLE_VALUE_W;
   localparam int PROD_W   = TV_W + GAIN_W + 1;
   localparam int ACC_W    = wtmix_pkg::PERIOD_W + MIX_SHIFT + GAIN_W + VOICE_AW + 3;
   localparam int DUTY_W   = wtmix_pkg::DUTY_W;
   localparam logic signed [ACC_W-1:0] DUTY_MAX = ACC_W'((1 << DUTY_W) - 1);

   logic [STEP_W-1:0] phase_mem [NUM_VOICES];
   logic [STEP_W-1:0] step_mem  [NUM_VOICES];
   logic [GAIN_W-1:0] vol_mem   [NUM_VOICES];
   logic [TV_W-1:0]   table_mem [TABLE_DEPTH];

   logic                       clr_voice_hit, clr_table_hit, set_hit, load_hit;
   logic [STEP_W-1:0]          s1_phase_ff, s1_step_ff, s1_new_phase;
   logic [GAIN_W-1:0]          s1_vol_ff, s2_vol_ff;
   logic [VOICE_AW-1:0]        s1_voice_ff;
   logic                       s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic signed [TV_W-1:0]     s2_tbl_ff;
   logic signed [PROD_W-1:0]   s3_prod_ff, s3_prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in, offset, sample;
   logic [DUTY_W-1:0]          duty_ff, duty_in;
   logic                       clip_ff, clip_in;

   assign clr_voice_hit = cmd.clr_we && (32'(clr_addr) < NUM_VOICES);
   assign clr_table_hit = cmd.clr_we && (32'(clr_addr) < TABLE_DEPTH);
   assign set_hit       = cmd.set_we && (32'(req_voice) < NUM_VOICES);
   assign load_hit      = cmd.load_we && (32'(req_table_index) < TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (clr_voice_hit) begin
         step_mem[clr_addr[VOICE_AW-1:0]] <= '0;
         vol_mem[clr_addr[VOICE_AW-1:0]]  <= '0;
      end else if (set_hit) begin
         step_mem[VOICE_AW'(req_voice)] <= req_phase_step;
         vol_mem[VOICE_AW'(req_voice)]  <= (req_phase_step == '0) ? '0 : req_gain;
      end
   end

   assign s1_new_phase = s1_phase_ff + s1_step_ff;

   always_ff @(posedge clock) begin
      if (clr_voice_hit) begin
         phase_mem[clr_addr[VOICE_AW-1:0]] <= '0;
      end else if (s1_vld_ff) begin
         phase_mem[s1_voice_ff] <= s1_new_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_table_hit) begin
         table_mem[clr_addr[TABLE_AW-1:0]] <= '0;
      end else if (load_hit) begin
         table_mem[TABLE_AW'(req_table_index)] <= req_table_value;
      end
   end

   always_ff @(posedge clock) begin
      s1_phase_ff <= phase_mem[issue_voice];
      s1_step_ff  <= step_mem[issue_voice];
      s1_vol_ff   <= vol_mem[issue_voice];
      s1_voice_ff <= issue_voice;
      s2_tbl_ff   <= table_mem[s1_new_phase[PHASE_FRAC_BITS +: TABLE_AW]];
      s2_vol_ff   <= s1_vol_ff;
      s3_prod_ff  <= s3_prod_in;
      acc_ff      <= acc_in;
      duty_ff     <= duty_in;
      clip_ff     <= clip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   assign s3_prod_in = PROD_W'(s2_tbl_ff) * PROD_W'($signed({1'b0, s2_vol_ff}));
   assign offset     = $signed((ACC_W'(pwm_period) << MIX_SHIFT) >> 1);
   assign sample     = acc_ff >>> MIX_SHIFT;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_init) begin
         acc_in = offset;
      end else if (s3_vld_ff) begin
         acc_in = acc_ff + ACC_W'(s3_prod_ff);
      end
   end

   always_comb begin
      duty_in = duty_ff;
      clip_in = clip_ff;
      if (cmd.out_load) begin
         priority if (sample < 0) begin
            duty_in = '0;
            clip_in = 1'b1;
         end else if (sample > DUTY_MAX) begin
            duty_in = '1;
            clip_in = 1'b1;
         end else begin
            duty_in = sample[DUTY_W-1:0];
            clip_in = 1'b0;
         end
      end
   end

   assign pipe_busy = s1_vld_ff || s2_vld_ff || s3_vld_ff;
   assign duty      = duty_ff;
   assign clipped   = clip_ff;

`ifndef SYNTHESIS
   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_init |-> !pipe_busy)
      else $error("accumulator restarted while products in flight");
   a_load_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!pipe_busy && !cmd.issue))
      else $error("result taken before accumulation finished");
`endif

endmodule

FILE: hdl/polyphonic_wavetable_tone_mixer.sv
// ----------------------------------------------------------------------------
// polyphonic_wavetable_tone_mixer
// Multi-voice wavetable synthesizer mixing all voices into a PWM duty value.
// ----------------------------------------------------------------------------
// usage
//   req_if: func 0 sets a voice step and gain, func 2 loads one table entry,
//   func 1 advances every voice and mixes one sample; func 3 is dropped.
//   rsp_if: one duty/clipped beat per sample request, none for the others.
//   csr: register 0 at byte address 0 holds pwm_period (reset 1406).
// timing
//   set-voice and table-load beats are written to memory as they are taken.
//   a sample beat issues its voices one per cycle through a shared lookup and
//   multiply-accumulate pipeline.
// reset
//   memories are swept to zero over max(TABLE_DEPTH, NUM_VOICES) addresses;
//   req_if.ready stays low until the sweep ends.
// stall
//   a finished beat sits in the output register; the next request is still
//   taken, and the next sample waits at its end until the beat is taken.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_tone_mixer #(
   parameter int NUM_VOICES      = wtmix_pkg::NUM_VOICES_DEF,
   parameter int TABLE_DEPTH     = wtmix_pkg::TABLE_DEPTH_DEF,
   parameter int PHASE_FRAC_BITS = wtmix_pkg::PHASE_FRAC_BITS_DEF,
   parameter int MIX_SHIFT       = wtmix_pkg::MIX_SHIFT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   wtmix_req_if.sink                           req_if,
   wtmix_rsp_if.source                         rsp_if,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wtmix_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wtmix_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wtmix_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   localparam int CLR_DEPTH = (TABLE_DEPTH > NUM_VOICES) ? TABLE_DEPTH : NUM_VOICES;
   localparam int VOICE_AW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CLR_AW    = $clog2(CLR_DEPTH);

   logic [wtmix_pkg::PERIOD_W-1:0] pwm_period_ff, pwm_period_in;
   logic                           csr_hit;
   wtmix_pkg::cmd_type             cmd;
   logic [VOICE_AW-1:0]            issue_voice;
   logic [CLR_AW-1:0]              clr_addr;
   logic                           pipe_busy;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == wtmix_pkg::CSR_PWM_PERIOD);

   always_comb begin
      pwm_period_in = pwm_period_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         pwm_period_in = csr_pwdata[wtmix_pkg::PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff <= wtmix_pkg::PWM_PERIOD_RESET;
      end else begin
         pwm_period_ff <= pwm_period_in;
      end
   end

   assign csr_prdata = csr_hit ? wtmix_pkg::CSR_DATA_W'(pwm_period_ff) : '0;

   wtmix_ctrl #(
      .NUM_VOICES (NUM_VOICES),
      .CLR_DEPTH  (CLR_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_func    (req_if.func),
      .req_ready   (req_if.ready),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .pipe_busy   (pipe_busy),
      .cmd         (cmd),
      .issue_voice (issue_voice),
      .clr_addr    (clr_addr)
   );

   wtmix_dp #(
      .NUM_VOICES      (NUM_VOICES),
      .TABLE_DEPTH     (TABLE_DEPTH),
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
      .MIX_SHIFT       (MIX_SHIFT),
      .CLR_DEPTH       (CLR_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .issue_voice     (issue_voice),
      .clr_addr        (clr_addr),
      .req_voice       (req_if.voice),
      .req_phase_step  (req_if.phase_step),
      .req_gain        (req_if.gain),
      .req_table_index (req_if.table_index),
      .req_table_value (req_if.table_value),
      .pwm_period      (pwm_period_ff),
      .pipe_busy       (pipe_busy),
      .duty            (rsp_if.duty),
      .clipped         (rsp_if.clipped)
   );

endmodule

FILE: test/tb_polyphonic_wavetable_tone_mixer.sv
// ----------------------------------------------------------------------------
// tb_polyphonic_wavetable_tone_mixer
// Self-checking bench for the sixteen-voice wavetable tone mixer. Drives
// voice setup, table load and sample beats, predicts every duty beat from a
// local copy of the voice state and sine table, and checks each returned
// beat in order, under random source and sink idling, a long output stall
// and several pwm_period settings written over the APB port.
// ----------------------------------------------------------------------------
module tb_polyphonic_wavetable_tone_mixer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [wtmix_pkg::FUNC_W-1:0]     FUNC_UNUSED   = 2'd3;
   localparam logic [wtmix_pkg::CSR_ADDR_W-1:0] PERIOD_ADDR   =
      wtmix_pkg::CSR_ADDR_W'(4 * int'(wtmix_pkg::CSR_PWM_PERIOD));
   localparam int NUM_VOICES    = wtmix_pkg::NUM_VOICES_DEF;
   localparam int TABLE_DEPTH   = wtmix_pkg::TABLE_DEPTH_DEF;
   localparam int SETTLE_CYCLES = wtmix_pkg::NUM_VOICES_DEF + 16;
   localparam int RESET_CYCLES  = 11;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [wtmix_pkg::FUNC_W-1:0]        func;
      logic [wtmix_pkg::VOICE_W-1:0]       voice;
      logic [wtmix_pkg::STEP_W-1:0]        phase_step;
      logic [wtmix_pkg::GAIN_W-1:0]        gain;
      logic [wtmix_pkg::TABLE_INDEX_W-1:0] table_index;
      logic [wtmix_pkg::TABLE_VALUE_W-1:0] table_value;
   } tone_req_type;

   typedef struct packed {
      logic [wtmix_pkg::DUTY_W-1:0] duty;
      logic                         clipped;
   } duty_beat_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [wtmix_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [wtmix_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [wtmix_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   wtmix_req_if req_bus ();
   wtmix_rsp_if rsp_bus ();

   polyphonic_wavetable_tone_mixer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // mixer state as the bench sees it
   logic [wtmix_pkg::STEP_W-1:0]        voice_phase [NUM_VOICES];
   logic [wtmix_pkg::STEP_W-1:0]        voice_step  [NUM_VOICES];
   logic [wtmix_pkg::GAIN_W-1:0]        voice_gain  [NUM_VOICES];
   logic [wtmix_pkg::TABLE_VALUE_W-1:0] sine_table  [TABLE_DEPTH];
   logic [wtmix_pkg::PERIOD_W-1:0]      period_setting = wtmix_pkg::PWM_PERIOD_RESET;

   duty_beat_type pending_duty_q [$];
   int            mismatch_count = 0;
   int            send_idle_pct  = 0;
   int            recv_idle_pct  = 0;
   int            hold_left      = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void note_mismatch(input string what, input longint want,
                                         input longint got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
   endfunction

   // applies a beat to the bench state; a sample beat advances the voices and queues the duty it should give
   function automatic void apply_tone_req(input tone_req_type beat);
      longint                              mix_sum;
      longint                              level;
      logic [wtmix_pkg::TABLE_INDEX_W-1:0] tidx;
      duty_beat_type                       res;
      case (beat.func)
         wtmix_pkg::FUNC_SET_VOICE: begin
            voice_step[beat.voice] = beat.phase_step;
            voice_gain[beat.voice] = (beat.phase_step == '0) ? '0 : beat.gain;
         end
         wtmix_pkg::FUNC_LOAD_TABLE: begin
            sine_table[beat.table_index] = beat.table_value;
         end
         wtmix_pkg::FUNC_SAMPLE: begin
            mix_sum = 0;
            for (int v = 0; v < NUM_VOICES; v++) begin
               voice_phase[v] = voice_phase[v] + voice_step[v];
               tidx = voice_phase[v][wtmix_pkg::PHASE_FRAC_BITS_DEF +:
                                     wtmix_pkg::TABLE_INDEX_W];
               mix_sum += longint'($signed(sine_table[tidx])) * longint'(voice_gain[v]);
            end
            level = (mix_sum + (longint'(period_setting) << (wtmix_pkg::MIX_SHIFT_DEF - 1)))
                    >>> wtmix_pkg::MIX_SHIFT_DEF;
            if (level < 0) begin
               res.duty    = '0;
               res.clipped = 1'b1;
            end else if (level > 65535) begin
               res.duty    = '1;
               res.clipped = 1'b1;
            end else begin
               res.duty    = level[wtmix_pkg::DUTY_W-1:0];
               res.clipped = 1'b0;
            end
            pending_duty_q.push_back(res);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic tone_req_type tone_cmd(
      input logic [wtmix_pkg::FUNC_W-1:0]        func,
      input logic [wtmix_pkg::VOICE_W-1:0]       voice,
      input logic [wtmix_pkg::STEP_W-1:0]        phase_step,
      input logic [wtmix_pkg::GAIN_W-1:0]        gain,
      input logic [wtmix_pkg::TABLE_INDEX_W-1:0] table_index,
      input logic [wtmix_pkg::TABLE_VALUE_W-1:0] table_value);
      tone_req_type beat;
      beat.func        = func;
      beat.voice       = voice;
      beat.phase_step  = phase_step;
      beat.gain        = gain;
      beat.table_index = table_index;
      beat.table_value = table_value;
      return beat;
   endfunction

   // valid is left high after a beat; the next call drives a new beat or lowers it to idle, and a drain lowers it
   task automatic send_beat(input tone_req_type beat);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= beat.func;
      req_bus.voice       <= beat.voice;
      req_bus.phase_step  <= beat.phase_step;
      req_bus.gain        <= beat.gain;
      req_bus.table_index <= beat.table_index;
      req_bus.table_value <= beat.table_value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_tone_req(beat);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_duty_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_pwm_period(input logic [wtmix_pkg::PERIOD_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PERIOD_ADDR;
      csr_pwdata  <= wtmix_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      period_setting = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata != wtmix_pkg::CSR_DATA_W'(value))
         note_mismatch("pwm_period readback", value, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_random_items(input int count);
      tone_req_type beat;
      int           pick;
      for (int n = 0; n < count; n++) begin
         beat.voice       = wtmix_pkg::VOICE_W'($urandom_range(NUM_VOICES - 1));
         beat.gain        = wtmix_pkg::GAIN_W'($urandom_range(255));
         beat.table_index = wtmix_pkg::TABLE_INDEX_W'($urandom_range(TABLE_DEPTH - 1));
         beat.table_value = wtmix_pkg::TABLE_VALUE_W'($urandom);
         case ($urandom_range(7))
            0:       beat.phase_step = '0;
            1, 2, 3: beat.phase_step = $urandom_range(32'h0001_FFFF, 1);
            default: beat.phase_step = $urandom;
         endcase
         pick = $urandom_range(99);
         if (pick < 40)
            beat.func = wtmix_pkg::FUNC_SAMPLE;
         else if (pick < 68)
            beat.func = wtmix_pkg::FUNC_SET_VOICE;
         else if (pick < 96)
            beat.func = wtmix_pkg::FUNC_LOAD_TABLE;
         else
            beat.func = FUNC_UNUSED;
         send_beat(beat);
      end
   endtask

   task automatic test_directed_voices();
      send_beat(tone_cmd(wtmix_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
      send_beat(tone_cmd(wtmix_pkg::FUNC_LOAD_TABLE, 0, 0, 0, 0, 16'h7FFF));
      send_beat(tone_cmd(wtmix_pkg::FUNC_LOAD_TABLE, 0, 0, 0, 127, 16'h8000));
      send_beat(tone_cmd(wtmix_pkg::FUNC_LOAD_TABLE, 0, 0, 0, 64, 16'h0001));
      send_beat(tone_cmd(wtmix_pkg::FUNC_SET_VOICE, 0, 32'h0000_0400, 255, 0, 0));
      send_beat(tone_cmd(wtmix_pkg::FUNC_SET_VOICE, 15, 32'hFFFF_FC00, 255, 0, 0));
      // zero step must silence the voice
      send_beat(tone_cmd(wtmix_pkg::FUNC_SET_VOICE, 7, 32'h0, 255, 0, 0));
      send_beat(tone_cmd(wtmix_pkg::FUNC_SET_VOICE, 2, 32'h1, 0, 0, 0));
      send_beat(tone_cmd(FUNC_UNUSED, '1, '1, '1, '1, '1));
      repeat (3) send_beat(tone_cmd(wtmix_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
      // new step keeps the running phase
      send_beat(tone_cmd(wtmix_pkg::FUNC_SET_VOICE, 0, 32'h0002_0000, 1, 0, 0));
      send_beat(tone_cmd(wtmix_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
      send_beat(tone_cmd(wtmix_pkg::FUNC_SET_VOICE, 15, 32'hFFFF_FFFF, 128, 0, 0));
      send_beat(tone_cmd(wtmix_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
      // full negative swing drives the duty below zero
      send_beat(tone_cmd(wtmix_pkg::FUNC_LOAD_TABLE, 0, 0, 0, 0, 16'h8000));
      send_beat(tone_cmd(wtmix_pkg::FUNC_SET_VOICE, 1, 32'h0002_0000, 255, 0, 0));
      send_beat(tone_cmd(wtmix_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
      send_beat(tone_cmd(wtmix_pkg::FUNC_SET_VOICE, 15, 32'h0, 255, 0, 0));
      send_beat(tone_cmd(wtmix_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
      wait_drained();
   endtask

   task automatic test_traffic_phase(input logic [wtmix_pkg::PERIOD_W-1:0] period,
                                     input int src_pct, input int snk_pct,
                                     input int count);
      write_pwm_period(period);
      send_idle_pct = src_pct;
      recv_idle_pct = snk_pct;
      send_random_items(count);
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      write_pwm_period(wtmix_pkg::PWM_PERIOD_RESET);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = HOLD_CYCLES;
      repeat (12) send_beat(tone_cmd(wtmix_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
      wait_drained();
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      duty_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_duty_q.size() == 0) begin
            note_mismatch("duty beat with none pending", -1, rsp_bus.duty);
         end else begin
            want = pending_duty_q.pop_front();
            if (rsp_bus.duty != want.duty)
               note_mismatch("duty", want.duty, rsp_bus.duty);
            if (rsp_bus.clipped != want.clipped)
               note_mismatch("clipped", want.clipped, rsp_bus.clipped);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      for (int v = 0; v < NUM_VOICES; v++) begin
         voice_phase[v] = '0;
         voice_step[v]  = '0;
         voice_gain[v]  = '0;
      end
      for (int t = 0; t < TABLE_DEPTH; t++) sine_table[t] = '0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.func        = '0;
      req_bus.voice       = '0;
      req_bus.phase_step  = '0;
      req_bus.gain        = '0;
      req_bus.table_index = '0;
      req_bus.table_value = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_voices();
      test_traffic_phase(16'($urandom_range(65534, 2)), 19, 88, 140);
      test_traffic_phase(16'd65534, 88, 19, 140);
      test_traffic_phase(16'd2, 0, 0, 140);
      test_output_backpressure();

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
